// ===== rtl/wml_pkg.sv =====
package wml_pkg;

  localparam int FrameRows = 64;
  localparam int FrameCols = 64;
  localparam int RowW = $clog2(FrameRows);
  localparam int ColW = $clog2(FrameCols);
  localparam int AddrW = RowW + ColW;
  localparam int MaxRadius = 3;
  localparam int WinMax = (2 * MaxRadius + 1) * (2 * MaxRadius + 1);
  localparam int CntW = $clog2(WinMax + 1);
  localparam int PixW = 8;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 7;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegBorderTop    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegBorderBottom = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBorderLeft   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegBorderRight  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegWindowRadius = 3'd4;

  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StSort,
    StOut
  } state_e;

  // request from scan control towards the selection unit
  typedef struct packed {
    logic             clear;
    logic             push;
    logic [PixW-1:0]  pix;
  } sel_ctrl_t;

  // intensity (3r+6g+b)/10 truncated: multiply by reciprocal with correction
  function automatic logic [PixW-1:0] luma(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
    logic [11:0] s;
    logic [23:0] p;
    logic [11:0] q;
    logic [11:0] rem;
    begin
      s   = 12'(3 * r) + 12'(6 * g) + 12'(b);
      p   = 24'(s) * 24'd3277;
      q   = 12'(p >> 15);
      rem = s - 12'(q * 12'd10);
      if (rem >= 12'd10) q = q + 12'd1;
      else if (rem[11]) q = q - 12'd1;
      luma = q[PixW-1:0];
    end
  endfunction

endpackage

// ===== rtl/wml_frame_ram.sv =====
module wml_frame_ram import wml_pkg::*; (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [PixW-1:0]  wdata_i,
  output logic [PixW-1:0]  rdata_o
);

  logic [PixW-1:0] mem [2**AddrW];

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end

endmodule

// ===== rtl/wml_select.sv =====
module wml_select import wml_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sel_ctrl_t       ctrl_i,
  input  logic            start_i,
  output logic            done_o,
  output logic [PixW-1:0] median_o
);

  // insertion list kept sorted, one insert per cycle
  logic [PixW-1:0] list_q [WinMax];
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] tgt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctrl_i.clear) begin
      cnt_q <= '0;
    end else if (ctrl_i.push) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // each slot takes its neighbour or the new value
  for (genvar i = 0; i < WinMax; i++) begin : g_slot
    if (i == 0) begin : g_head
      always_ff @(posedge clk_i) begin
        if (ctrl_i.push && !ctrl_i.clear) begin
          if (list_q[0] > ctrl_i.pix || cnt_q == '0) list_q[0] <= ctrl_i.pix;
        end
      end
    end else begin : g_body
      always_ff @(posedge clk_i) begin
        if (ctrl_i.push && !ctrl_i.clear && CntW'(i) <= cnt_q) begin
          if (list_q[i-1] > ctrl_i.pix) begin
            list_q[i] <= list_q[i-1];
          end else if (CntW'(i) == cnt_q || list_q[i] > ctrl_i.pix) begin
            list_q[i] <= ctrl_i.pix;
          end
        end
      end
    end
  end

  assign tgt = cnt_q >> 1;

  // pick upper middle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) median_o <= list_q[tgt];
  end

endmodule

// ===== rtl/window_median_luma.sv =====
// throughput: one request at a time; frame memory port reads one window entry a cycle
// reset: border and radius registers to defaults, control idle; frame memory
// holds no reset and must be written before it is read
module window_median_luma import wml_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // op, row, col, red, green, blue; zero pad
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // median
  output logic        m_axis_tuser_o,  // empty_window
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  state_e state_q, state_d;
  logic [6:0] top_q, bot_q, lft_q, rgt_q;
  logic [1:0] rad_q;
  logic [RowW-1:0] crow_q;
  logic [ColW-1:0] ccol_q;
  logic signed [3:0] dr_q, dc_q;
  logic rd_vld_q, any_q, sel_done;
  logic signed [8:0] r_abs, c_abs;
  logic in_pic, last_pos, acc;
  logic [PixW-1:0] rdata, med;
  logic ram_we;
  logic [AddrW-1:0] ram_addr;
  sel_ctrl_t sel;
  logic op;

  assign cfg_ready_o = 1'b1;
  assign op = s_axis_tdata_i[0];
  assign s_axis_tready_o = (state_q == StIdle);
  assign acc = s_axis_tvalid_i && s_axis_tready_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= 7'd0; bot_q <= 7'd64; lft_q <= 7'd0; rgt_q <= 7'd64; rad_q <= 2'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegBorderTop:    top_q <= cfg_data_i;
        RegBorderBottom: bot_q <= cfg_data_i;
        RegBorderLeft:   lft_q <= cfg_data_i;
        RegBorderRight:  rgt_q <= cfg_data_i;
        RegWindowRadius: rad_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // window position
  assign r_abs = $signed({3'b0, crow_q}) + 9'(dr_q);
  assign c_abs = $signed({3'b0, ccol_q}) + 9'(dc_q);
  assign in_pic = r_abs >= 0 && c_abs >= 0 && r_abs < FrameRows && c_abs < FrameCols
               && r_abs >= $signed({2'b0, top_q}) && r_abs < $signed({2'b0, bot_q})
               && c_abs >= $signed({2'b0, lft_q}) && c_abs < $signed({2'b0, rgt_q});
  assign last_pos = dr_q == $signed({2'b0, rad_q}) && dc_q == $signed({2'b0, rad_q});

  // memory port mux
  always_comb begin
    ram_we = acc && op == OpWrite;
    if (state_q == StScan) ram_addr = {r_abs[RowW-1:0], c_abs[ColW-1:0]};
    else ram_addr = {s_axis_tdata_i[RowW:1], s_axis_tdata_i[RowW+ColW:RowW+1]};
  end

  wml_frame_ram u_ram (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr),
    .wdata_i(luma(s_axis_tdata_i[20:13], s_axis_tdata_i[28:21], s_axis_tdata_i[36:29])),
    .rdata_o(rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (acc && op == OpQuery) state_d = StScan;
      StScan: if (last_pos) state_d = StSort;
      StSort: if (!rd_vld_q) state_d = StOut;
      StOut:  if (sel_done) state_d = StOut;
              else if (m_axis_tvalid_o && m_axis_tready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // state, scan counters and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; rd_vld_q <= 1'b0; any_q <= 1'b0;
      dr_q <= '0; dc_q <= '0; crow_q <= '0; ccol_q <= '0;
      m_axis_tvalid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_vld_q <= state_q == StScan && in_pic;
      if (acc && op == OpQuery) begin
        crow_q <= s_axis_tdata_i[RowW:1];
        ccol_q <= s_axis_tdata_i[RowW+ColW:RowW+1];
        dr_q <= -$signed({2'b0, rad_q});
        dc_q <= -$signed({2'b0, rad_q});
        any_q <= 1'b0;
      end else if (state_q == StScan) begin
        if (in_pic) any_q <= 1'b1;
        if (dr_q == $signed({2'b0, rad_q})) begin
          dr_q <= -$signed({2'b0, rad_q});
          dc_q <= dc_q + 4'sd1;
        end else begin
          dr_q <= dr_q + 4'sd1;
        end
      end
      if (sel_done) m_axis_tvalid_o <= 1'b1;
      else if (m_axis_tready_i) m_axis_tvalid_o <= 1'b0;
    end
  end

  // selection requests
  always_comb begin
    sel.clear = acc && op == OpQuery;
    sel.push  = rd_vld_q;
    sel.pix   = rdata;
  end

  wml_select u_sel (
    .clk_i, .rst_ni, .ctrl_i(sel),
    .start_i(state_q == StSort && !rd_vld_q),
    .done_o(sel_done), .median_o(med)
  );

  // outputs
  assign m_axis_tuser_o = !any_q;
  assign m_axis_tdata_o = any_q ? med : 8'd0;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> state_q == StOut)
    else $error("result valid outside output state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(state_q) == StScan)
    else $error("memory read outside scan");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_done |=> m_axis_tvalid_o)
    else $error("result lost");

endmodule

// ===== tb/window_median_luma_test.sv =====
`timescale 1ns / 1ps

module window_median_luma_test;
  import wml_pkg::*;

  // register indexes past the end of the list, writes to them are dropped
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;
  localparam logic [CfgIdxW-1:0] RegSpare  = 3'd5;
  localparam int  DrainCycles = 64;
  // random queries stay in this block of centres so window filling stays bounded
  localparam int  QryLo = 16;
  localparam int  QryHi = 31;

  typedef struct {
    logic       op;
    logic [5:0] row;
    logic [5:0] col;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_req_t;

  typedef struct {
    logic [7:0] median;
    logic       empty_window;
  } median_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [7:0]  m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  window_median_luma dut (.*);

  // shadow of the block: frame contents, which entries hold data, registers
  logic [7:0] luma_frame [FrameRows][FrameCols];
  bit         pixel_set  [FrameRows][FrameCols];
  logic [6:0] top_q, bottom_q, left_q, right_q;
  logic [1:0] radius_q;

  median_res_t median_pending[$];
  int  err_count;
  int  n_writes, n_queries, n_empty, n_checked;
  bit  no_idle;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // overall time limit
  initial begin
    #60_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic bit in_picture(int r, int c);
    if (r < 0 || c < 0 || r >= FrameRows || c >= FrameCols) return 0;
    if (r < top_q || r >= bottom_q) return 0;
    if (c < left_q || c >= right_q) return 0;
    return 1;
  endfunction

  function automatic logic [7:0] pixel_luma(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int s;
    s = 3 * r + 6 * g + b;
    return 8'(s / 10);
  endfunction

  // upper median of the window by a running histogram count
  function automatic median_res_t window_median(logic [5:0] row, logic [5:0] col);
    int hist[256];
    int rad, cnt, cum;
    median_res_t res;
    rad = (radius_q > MaxRadius) ? MaxRadius : radius_q;
    cnt = 0;
    cum = 0;
    res.median = 8'd0;
    res.empty_window = 1'b0;
    foreach (hist[v]) hist[v] = 0;
    for (int dr = -rad; dr <= rad; dr++)
      for (int dc = -rad; dc <= rad; dc++)
        if (in_picture(row + dr, col + dc)) begin
          hist[luma_frame[row + dr][col + dc]]++;
          cnt++;
        end
    if (cnt == 0) begin
      res.empty_window = 1'b1;
      return res;
    end
    for (int v = 0; v < 256; v++) begin
      cum += hist[v];
      if (cum > cnt / 2) begin
        res.median = 8'(v);
        break;
      end
    end
    return res;
  endfunction

  // send one request, leaves tvalid high; random gap before it
  task automatic send_request(pixel_req_t req);
    median_res_t res;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    s_axis_tdata_i  = {3'b000, req.blue, req.green, req.red, req.col, req.row, req.op};
    s_axis_tvalid_i = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (req.op == OpWrite) begin
      luma_frame[req.row][req.col] = pixel_luma(req.red, req.green, req.blue);
      pixel_set[req.row][req.col]  = 1'b1;
      n_writes++;
    end else begin
      res = window_median(req.row, req.col);
      median_pending.insert(median_pending.size(), res);
      n_queries++;
      if (res.empty_window) n_empty++;
    end
    @(negedge clk_i);
  endtask

  task automatic write_pixel(logic [5:0] row, logic [5:0] col,
                             logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pixel_req_t req;
    req = '{OpWrite, row, col, r, g, b};
    send_request(req);
  endtask

  // fill any unwritten in-picture entry of the window, then query
  task automatic query_at(logic [5:0] row, logic [5:0] col);
    pixel_req_t req;
    int rad;
    rad = radius_q;
    for (int dr = -rad; dr <= rad; dr++)
      for (int dc = -rad; dc <= rad; dc++)
        if (in_picture(row + dr, col + dc) && !pixel_set[row + dr][col + dc])
          write_pixel(6'(row + dr), 6'(col + dc), 8'($urandom), 8'($urandom),
                      8'($urandom));
    req = '{OpQuery, row, col, 8'($urandom), 8'($urandom), 8'($urandom)};
    send_request(req);
  endtask

  // wait for every expected result, then for any write still in flight
  task automatic wait_idle();
    s_axis_tvalid_i = 1'b0;
    while (median_pending.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_index_i = idx;
    cfg_data_i  = data;
    cfg_valid_i = 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      RegBorderTop:    top_q    = data;
      RegBorderBottom: bottom_q = data;
      RegBorderLeft:   left_q   = data;
      RegBorderRight:  right_q  = data;
      RegWindowRadius: radius_q = data[1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_window(logic [6:0] t, logic [6:0] bt, logic [6:0] l,
                            logic [6:0] rt, logic [6:0] rad);
    wait_idle();
    write_reg(RegBorderTop, t);
    write_reg(RegBorderBottom, bt);
    write_reg(RegBorderLeft, l);
    write_reg(RegBorderRight, rt);
    write_reg(RegWindowRadius, rad);
  endtask

  // extremes of the pixel fields and the frame corners
  task automatic test_directed_corners();
    write_pixel(6'd0, 6'd0, 8'hFF, 8'hFF, 8'hFF);
    write_pixel(6'd63, 6'd63, 8'h00, 8'h00, 8'h00);
    write_pixel(6'd0, 6'd63, 8'hFF, 8'h00, 8'h00);
    write_pixel(6'd63, 6'd0, 8'h00, 8'h00, 8'hFF);
    set_window(7'd0, 7'd64, 7'd0, 7'd64, 7'd0);
    query_at(6'd0, 6'd0);
    query_at(6'd63, 6'd63);
    query_at(6'd0, 6'd63);
    query_at(6'd63, 6'd0);
    set_window(7'd0, 7'd127, 7'd0, 7'd127, 7'd3);
    query_at(6'd0, 6'd0);
    query_at(6'd63, 6'd63);
  endtask

  // empty, inverted and beyond-frame borders, radius truncation, dead index
  task automatic test_border_cases();
    set_window(7'd64, 7'd0, 7'd0, 7'd64, 7'd1);
    query_at(6'd10, 6'd10);
    set_window(7'd20, 7'd20, 7'd5, 7'd60, 7'd2);
    query_at(6'd20, 6'd20);
    set_window(7'd10, 7'd12, 7'd30, 7'd33, 7'h7F);
    query_at(6'd8, 6'd29);
    query_at(6'd14, 6'd36);
    query_at(6'd11, 6'd31);
    wait_idle();
    write_reg(RegUnused, 7'h55);
    write_reg(RegSpare, 7'h2A);
    query_at(6'd12, 6'd32);
  endtask

  // random items across several register settings
  task automatic test_random_phases(int phases, int per_phase);
    pixel_req_t req;
    logic [6:0] t, l;
    for (int p = 0; p < phases; p++) begin
      if (p == 0)
        set_window(7'd0, 7'd64, 7'd0, 7'd64, 7'd1);
      else begin
        t = 7'($urandom_range(0, 24));
        l = 7'($urandom_range(0, 24));
        set_window(t, 7'($urandom_range(t, 127)), l, 7'($urandom_range(l, 127)),
                   7'($urandom));
      end
      for (int i = 0; i < per_phase; i++) begin
        if ($urandom_range(0, 1)) begin
          req = '{OpWrite, 6'($urandom), 6'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom)};
          send_request(req);
        end else
          query_at(6'($urandom_range(QryLo, QryHi)), 6'($urandom_range(QryLo, QryHi)));
      end
    end
  endtask

  // hold the sender until everything has come back, then carry on
  task automatic test_drain_pause();
    query_at(6'($urandom), 6'($urandom));
    query_at(6'($urandom), 6'($urandom));
    wait_idle();
    query_at(6'($urandom), 6'($urandom));
  endtask

  // result receiver stall bursts
  initial begin
    m_axis_tready_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!no_idle && $urandom_range(0, 5) == 0) begin
        m_axis_tready_i = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
      m_axis_tready_i = 1'b1;
    end
  end

  // compare each result with the oldest expected median
  always @(posedge clk_i) begin
    median_res_t exp_res;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (median_pending.size() == 0) begin
        $error("result with no query pending: median %0d empty %0d",
               m_axis_tdata_o, m_axis_tuser_o);
        err_count++;
      end else begin
        exp_res = median_pending.pop_front();
        n_checked++;
        if (m_axis_tdata_o !== exp_res.median) begin
          $error("median: expected %0d, actual %0d", exp_res.median, m_axis_tdata_o);
          err_count++;
        end
        if (m_axis_tuser_o !== exp_res.empty_window) begin
          $error("empty_window: expected %0d, actual %0d",
                 exp_res.empty_window, m_axis_tuser_o);
          err_count++;
        end
      end
    end
  end

  // main sequence
  initial begin
    err_count = 0;
    n_writes = 0;
    n_queries = 0;
    n_empty = 0;
    n_checked = 0;
    no_idle = 1'b0;
    top_q = 7'd0;
    bottom_q = 7'd64;
    left_q = 7'd0;
    right_q = 7'd64;
    radius_q = 2'd1;
    foreach (pixel_set[r, c]) pixel_set[r][c] = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    rst_ni = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_corners();
    test_border_cases();
    test_random_phases(4, 60);
    test_drain_pause();
    no_idle = 1'b1;
    test_random_phases(1, 60);

    wait_idle();
    $display("covered %0d pixel writes and %0d median queries (%0d empty windows)",
             n_writes, n_queries, n_empty);
    $display("%0d results checked over several border and radius settings", n_checked);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/wml_pkg.sv
rtl/wml_frame_ram.sv
rtl/wml_select.sv
rtl/window_median_luma.sv
tb/window_median_luma_test.sv
